>>> src/jmsr_pkg.sv
// shared types and constants for the jpeg marker stream repair unit
package jmsr_pkg;

  localparam int LengthBits = 24;
  localparam int QDepth     = 2;
  localparam int QAw        = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int MaxRes     = 4;

  typedef logic [LengthBits-1:0] len_t;
  typedef logic [LengthBits:0]   lenx_t;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] MRK_SOI  = 8'hD8;
  localparam logic [7:0] MRK_EOI  = 8'hD9;
  localparam logic [7:0] MRK_DROP = 8'hA0;
  localparam logic [7:0] MRK_SOF  = 8'hC0;
  localparam logic [7:0] MRK_DHT  = 8'hC4;
  localparam logic [7:0] MRK_DQT  = 8'hDB;
  localparam logic [7:0] MRK_SOS  = 8'hDA;
  localparam logic [7:0] MRK_APP0 = 8'hE0;
  localparam logic [7:0] SOS_LEN  = 8'h0C;
  localparam logic [7:0] SOS_SE   = 8'h3F;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MARK,
    MODE_LEN_LO,
    MODE_LEN_HI,
    MODE_BODY,
    MODE_SCAN,
    MODE_PASS,
    MODE_DONE
  } mode_t;

  // one queued command: up to four results caused by one input byte
  typedef struct packed {
    logic [MaxRes-1:0][7:0] dat;
    logic [2:0]             cnt;
    logic                   end_only;
    logic                   blk_end;
  } cmd_t;

endpackage

>>> src/jmsr_if.sv
// valid/ready channel interfaces for input bytes and repaired results
interface jmsr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        block_start;
  logic [23:0] block_length;

  modport source (output valid, data_byte, block_start, block_length, input ready);
  modport sink   (input valid, data_byte, block_start, block_length, output ready);
endinterface

interface jmsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       block_end;

  modport source (output valid, out_byte, byte_present, run_last, block_end, input ready);
  modport sink   (input valid, out_byte, byte_present, run_last, block_end, output ready);
endinterface

>>> src/jmsr_front.sv
// front end: accepts bytes, runs the marker parser and issues result commands
module jmsr_front
  import jmsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jmsr_in_if.sink   in_if,
  input  logic      q_full,
  output logic      push,
  output cmd_t      push_cmd
);

  mode_t       mode_r, mode_nxt, mode_c;
  logic        pend_r, pend_nxt, pend_c;
  logic        seg_scan_r, seg_scan_nxt, seg_scan_c;
  logic [7:0]  len_lo_r, len_lo_nxt, len_lo_c;
  logic [15:0] left_r, left_nxt, left_c;
  len_t        pos_r, pos_nxt, pos_c;
  len_t        total_r, total_nxt, total_c;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] seg_len;
  lenx_t       pos_p2;
  cmd_t        cmd;
  logic [2:0]  n;
  logic        fin;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign b           = in_if.data_byte;
  assign seg_len     = {b, len_lo_c};
  assign pos_p2      = {1'b0, pos_c} + lenx_t'(2);

  // parser state as seen by this byte, after a block start
  always_comb begin
    mode_c     = mode_r;
    pend_c     = pend_r;
    seg_scan_c = seg_scan_r;
    len_lo_c   = len_lo_r;
    left_c     = left_r;
    pos_c      = pos_r;
    total_c    = total_r;
    if (in_if.block_start) begin
      mode_c     = MODE_MARK;
      pend_c     = 1'b0;
      seg_scan_c = 1'b0;
      len_lo_c   = '0;
      left_c     = '0;
      pos_c      = '0;
      total_c    = len_t'({{LengthBits{1'b0}}, in_if.block_length});
    end
  end

  always_comb begin
    mode_nxt     = mode_c;
    pend_nxt     = pend_c;
    seg_scan_nxt = seg_scan_c;
    len_lo_nxt   = len_lo_c;
    left_nxt     = left_c;
    pos_nxt      = pos_c;
    total_nxt    = total_c;
    cmd          = '0;
    n            = '0;
    fin          = 1'b0;

    if (in_if.block_start && total_c == '0) begin
      mode_nxt     = MODE_DONE;
      n            = 3'd1;
      cmd.end_only = 1'b1;
      cmd.blk_end  = 1'b1;
    end else if (mode_c != MODE_IDLE && mode_c != MODE_DONE) begin
      case (mode_c)
        MODE_MARK: begin
          if (!pend_c) begin
            if (b == BYTE_FF) pend_nxt = 1'b1;
            else fin = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            cmd.dat[n[1:0]] = BYTE_FF; n = n + 3'd1;
            case (b)
              MRK_SOI: begin
                cmd.dat[n[1:0]] = b; n = n + 3'd1;
              end
              MRK_DROP: begin
                n = '0;
              end
              MRK_SOF, MRK_DHT, MRK_DQT: begin
                cmd.dat[n[1:0]] = b; n = n + 3'd1;
                seg_scan_nxt = 1'b0;
                mode_nxt     = MODE_LEN_LO;
              end
              MRK_SOS: begin
                cmd.dat[n[1:0]] = MRK_SOS; n = n + 3'd1;
                cmd.dat[n[1:0]] = BYTE_00; n = n + 3'd1;
                cmd.dat[n[1:0]] = SOS_LEN; n = n + 3'd1;
                seg_scan_nxt = 1'b1;
                mode_nxt     = MODE_LEN_LO;
              end
              MRK_EOI: begin
                cmd.dat[n[1:0]] = b; n = n + 3'd1;
                fin = 1'b1;
              end
              MRK_APP0: begin
                cmd.dat[n[1:0]] = b; n = n + 3'd1;
                mode_nxt = MODE_PASS;
              end
              BYTE_FF: begin
                pend_nxt = 1'b1;
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
        end
        MODE_LEN_LO: begin
          if (!seg_scan_c) begin
            cmd.dat[n[1:0]] = b; n = n + 3'd1;
          end
          len_lo_nxt = b;
          mode_nxt   = MODE_LEN_HI;
        end
        MODE_LEN_HI: begin
          if (!seg_scan_c) begin
            cmd.dat[n[1:0]] = b; n = n + 3'd1;
          end
          left_nxt = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
          if (left_nxt != '0) begin
            mode_nxt = MODE_BODY;
          end else if (seg_scan_c) begin
            cmd.dat[n[1:0]] = BYTE_00; n = n + 3'd1;
            cmd.dat[n[1:0]] = SOS_SE;  n = n + 3'd1;
            cmd.dat[n[1:0]] = BYTE_00; n = n + 3'd1;
            mode_nxt = MODE_SCAN;
          end else begin
            mode_nxt = MODE_MARK;
          end
        end
        MODE_BODY: begin
          cmd.dat[n[1:0]] = b; n = n + 3'd1;
          left_nxt = left_c - 16'd1;
          if (left_nxt == '0) begin
            if (seg_scan_c) begin
              cmd.dat[n[1:0]] = BYTE_00; n = n + 3'd1;
              cmd.dat[n[1:0]] = SOS_SE;  n = n + 3'd1;
              cmd.dat[n[1:0]] = BYTE_00; n = n + 3'd1;
              mode_nxt = MODE_SCAN;
            end else begin
              mode_nxt = MODE_MARK;
            end
          end
        end
        MODE_SCAN: begin
          if (pos_p2 < {1'b0, total_c}) begin
            cmd.dat[n[1:0]] = b; n = n + 3'd1;
            if (b == BYTE_FF) begin
              cmd.dat[n[1:0]] = BYTE_00; n = n + 3'd1;
            end
          end else if (pos_p2 == {1'b0, total_c}) begin
            cmd.dat[n[1:0]] = BYTE_FF; n = n + 3'd1;
          end else begin
            cmd.dat[n[1:0]] = MRK_EOI; n = n + 3'd1;
            fin = 1'b1;
          end
        end
        MODE_PASS: begin
          cmd.dat[n[1:0]] = b; n = n + 3'd1;
        end
        default: begin
        end
      endcase

      // length exhausted: flush a held ff and close the block
      if (!fin) begin
        pos_nxt = pos_c + len_t'(1);
        if (pos_nxt >= total_c) begin
          if (mode_nxt == MODE_MARK && pend_nxt) begin
            cmd.dat[n[1:0]] = BYTE_FF; n = n + 3'd1;
          end
          fin = 1'b1;
        end
      end
      if (fin) begin
        mode_nxt = MODE_DONE;
        pend_nxt = 1'b0;
        if (n == '0) begin
          n            = 3'd1;
          cmd.end_only = 1'b1;
        end
        cmd.blk_end = 1'b1;
      end
    end
    cmd.cnt = n;
  end

  assign push     = accept && (n != '0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pend_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg_scan_r <= seg_scan_nxt;
      len_lo_r   <= len_lo_nxt;
      left_r     <= left_nxt;
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
    end
  end

endmodule

>>> src/jmsr_queue.sv
// short command queue between the parser and the output serialiser
module jmsr_queue
  import jmsr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t           mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAw:0]   count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == (QAw+1)'(QDepth));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == (QAw)'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == (QAw)'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> src/jmsr_back.sv
// back end: serialises each queued command into result transfers
module jmsr_back
  import jmsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  jmsr_out_if.source out_if
);

  logic [1:0] idx_r;
  logic       last;
  logic       xfer;

  assign last = ({1'b0, idx_r} + 3'd1 == head.cnt);
  assign xfer = out_if.valid && out_if.ready;
  assign pop  = xfer && last;

  assign out_if.valid        = !empty;
  assign out_if.out_byte     = head.end_only ? BYTE_00 : head.dat[idx_r];
  assign out_if.byte_present = !head.end_only;
  assign out_if.run_last     = last;
  assign out_if.block_end    = last && head.blk_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (xfer) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

>>> src/jpeg_marker_stream_repair_unit.sv
// top level of the jpeg marker stream repair unit
// Repairs one modified jpeg block at a time, one input byte per transfer, into a
// standard marker stream. The first byte of a block carries block_start and the
// block length. A parser front end takes one byte per clock while its two-entry
// command queue has room; each byte becomes zero to four results (a marker's
// ff is held until its marker byte arrives, a scan ff gains a stuffed 00, an sos
// header gains its rebuilt length and 00 3f 00 tail). The back end hands out one
// result per clock while the receiver is ready; a byte with no result is accepted
// without a queue entry. Output stalls back up through the queue before they reach
// the input. run_last marks a byte's last result; block_end marks the block's
// last result, which is an end-only result with byte_present low where nothing
// else is due.
module jpeg_marker_stream_repair_unit
  import jmsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  jmsr_in_if.sink    in_if,
  jmsr_out_if.source out_if
);

  // queue hand-off between parser and serialiser
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  // parser: marker decode, segment length tracking, scan byte stuffing
  jmsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples input acceptance from output stalls
  jmsr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // one result transfer per clock from the queue head while the receiver is ready
  jmsr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

>>> src/jmsr_checker.sv
// port-level checks for the repair unit, bound to the top level
module jmsr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_present,
  input logic       run_last,
  input logic       block_end
);

  // an end-only result closes both the byte and the block
  a_end_only : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_present |-> run_last && block_end && out_byte == 8'h00)
    else $error("end-only result without run_last/block_end");

  // the block's last result is always a byte's last result
  a_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && block_end |-> run_last)
    else $error("block_end without run_last");

  // a stalled result holds
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(block_end) && $stable(byte_present))
    else $error("stalled result changed");

  // nothing is offered straight after reset
  a_reset_empty : assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind jpeg_marker_stream_repair_unit jmsr_checker u_jmsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_byte     (out_if.out_byte),
  .byte_present (out_if.byte_present),
  .run_last     (out_if.run_last),
  .block_end    (out_if.block_end)
);

>>> dv/tb_top.sv
// self-checking testbench for the jpeg marker stream repair unit
`timescale 1ns / 100ps

module tb_top
  import jmsr_pkg::*;
();

  localparam int TOTAL_ITEMS    = 370;   // input bytes that the parser acts on
  localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 16;    // quiet time after the last result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

  // one repaired result as it appears on the output channel
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       block_end;
  } rep_byte_t;

  logic clk;
  logic rst_n;

  jmsr_in_if  in_ch ();
  jmsr_out_if out_ch ();

  jpeg_marker_stream_repair_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always #1 clk = ~clk;

  // parser state mirrored by the predictor
  mode_t       pm_mode;
  logic        pm_ff_held;
  logic        pm_in_sos;
  logic [7:0]  pm_len_lo;
  logic [15:0] pm_seg_left;
  len_t        pm_pos;
  len_t        pm_total;

  rep_byte_t   byte_run[$];    // results of the byte being predicted
  rep_byte_t   repaired_q[$];  // results still to come out, oldest first
  logic [7:0]  byte_buf[$];    // bytes of the block about to be sent

  int          items_sent;
  int          faults;
  int          quiet_cycles;
  bit          tx_idle_on;
  bit          rx_stall_on;
  bit          rx_long_hold;

  function automatic void note_fault(input string what);
    faults++;
    if (faults <= 10) $display("[%0t] %s", $time, what);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // scan data is rich in ff so that stuffing is exercised often
  function automatic logic [7:0] scan_byte();
    return ($urandom_range(0, 3) == 0) ? BYTE_FF : rnd_byte();
  endfunction

  function automatic void emit(input logic [7:0] b, input logic present);
    rep_byte_t r;
    r.out_byte     = present ? b : 8'h00;
    r.byte_present = present;
    r.run_last     = 1'b0;
    r.block_end    = 1'b0;
    if (byte_run.size() < MaxRes) byte_run.push_back(r);
  endfunction

  // rebuilt sos header tail, then on into scan data
  function automatic void emit_sos_tail();
    emit(BYTE_00, 1'b1);
    emit(SOS_SE, 1'b1);
    emit(BYTE_00, 1'b1);
    pm_mode = MODE_SCAN;
  endfunction

  // works out the results of one accepted input byte and queues them
  function automatic void predict_repair(input logic [7:0] b, input logic st, input len_t len);
    logic                  fin;
    logic [15:0]           seg_len;
    logic [LengthBits+1:0] pos_ext;
    rep_byte_t             r;
    fin = 1'b0;
    byte_run.delete();
    if (st) begin
      pm_total    = len;
      pm_pos      = '0;
      pm_mode     = MODE_MARK;
      pm_ff_held  = 1'b0;
      pm_in_sos   = 1'b0;
      pm_len_lo   = '0;
      pm_seg_left = '0;
      if (len == '0) begin
        // empty block: a lone end-only result
        pm_mode = MODE_DONE;
        fin     = 1'b1;
      end
    end
    if (!fin) begin
      if (pm_mode == MODE_IDLE || pm_mode == MODE_DONE) return;
      case (pm_mode)
        MODE_MARK: begin
          if (!pm_ff_held) begin
            if (b == BYTE_FF) pm_ff_held = 1'b1;
            else fin = 1'b1;
          end else begin
            pm_ff_held = 1'b0;
            emit(BYTE_FF, 1'b1);
            case (b)
              MRK_SOI: emit(b, 1'b1);
              MRK_DROP: byte_run.delete();
              MRK_SOF, MRK_DHT, MRK_DQT: begin
                emit(b, 1'b1);
                pm_in_sos = 1'b0;
                pm_mode   = MODE_LEN_LO;
              end
              MRK_SOS: begin
                emit(MRK_SOS, 1'b1);
                emit(BYTE_00, 1'b1);
                emit(SOS_LEN, 1'b1);
                pm_in_sos = 1'b1;
                pm_mode   = MODE_LEN_LO;
              end
              MRK_EOI: begin
                emit(b, 1'b1);
                fin = 1'b1;
              end
              MRK_APP0: begin
                emit(b, 1'b1);
                pm_mode = MODE_PASS;
              end
              BYTE_FF: pm_ff_held = 1'b1;
              default: fin = 1'b1;
            endcase
          end
        end
        MODE_LEN_LO: begin
          if (!pm_in_sos) emit(b, 1'b1);
          pm_len_lo = b;
          pm_mode   = MODE_LEN_HI;
        end
        MODE_LEN_HI: begin
          seg_len = {b, pm_len_lo};
          if (!pm_in_sos) emit(b, 1'b1);
          pm_seg_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
          if (pm_seg_left != '0) pm_mode = MODE_BODY;
          else if (pm_in_sos) emit_sos_tail();
          else pm_mode = MODE_MARK;
        end
        MODE_BODY: begin
          emit(b, 1'b1);
          pm_seg_left = pm_seg_left - 16'd1;
          if (pm_seg_left == '0) begin
            if (pm_in_sos) emit_sos_tail();
            else pm_mode = MODE_MARK;
          end
        end
        MODE_SCAN: begin
          pos_ext = {2'b00, pm_pos} + (LengthBits+2)'(2);
          if (pos_ext < {2'b00, pm_total}) begin
            emit(b, 1'b1);
            if (b == BYTE_FF) emit(BYTE_00, 1'b1);
          end else if (pos_ext == {2'b00, pm_total}) begin
            emit(BYTE_FF, 1'b1);
          end else begin
            emit(MRK_EOI, 1'b1);
            fin = 1'b1;
          end
        end
        default: emit(b, 1'b1);
      endcase
      if (!fin) begin
        pm_pos = pm_pos + 1'b1;
        if (pm_pos >= pm_total) begin
          // length ran out: a held ff still goes out
          if (pm_mode == MODE_MARK && pm_ff_held) emit(BYTE_FF, 1'b1);
          fin = 1'b1;
        end
      end
    end
    if (fin) begin
      pm_mode    = MODE_DONE;
      pm_ff_held = 1'b0;
      if (byte_run.size() == 0) emit(8'h00, 1'b0);
    end
    for (int i = 0; i < byte_run.size(); i++) begin
      r = byte_run[i];
      if (i == byte_run.size() - 1) begin
        r.run_last  = 1'b1;
        r.block_end = fin;
      end
      repaired_q.push_back(r);
    end
  endfunction

  // offers one byte and waits for its transfer
  task automatic send_byte(input logic [7:0] b, input logic st, input len_t len);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.block_start  <= st;
    in_ch.block_length <= len;
    do @(posedge clk); while (!in_ch.ready);
    if (st || (pm_mode != MODE_IDLE && pm_mode != MODE_DONE)) items_sent++;
    predict_repair(b, st, len);
  endtask

  // length field only matters on the first byte, so the rest get junk there
  task automatic send_block(input int n, input len_t decl);
    for (int i = 0; i < n; i++)
      send_byte(byte_buf[i], i == 0, (i == 0) ? decl : len_t'($urandom()));
  endtask

  // sender goes quiet until every expected result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (repaired_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // well-formed block: soi, a few table segments, then sos and scan, eoi or app0
  function automatic void build_jpeg_block();
    int          nseg;
    int          body;
    int          ending;
    logic [7:0]  mk;
    logic [15:0] slen;
    byte_buf.delete();
    byte_buf.push_back(BYTE_FF);
    byte_buf.push_back(MRK_SOI);
    nseg = $urandom_range(0, 3);
    repeat (nseg) begin
      if ($urandom_range(0, 5) == 0) begin
        byte_buf.push_back(BYTE_FF);
        byte_buf.push_back(MRK_DROP);
      end
      case ($urandom_range(0, 2))
        0:       mk = MRK_SOF;
        1:       mk = MRK_DHT;
        default: mk = MRK_DQT;
      endcase
      body = $urandom_range(0, 5);
      slen = 16'(body + 2);
      if (body == 0 && $urandom_range(0, 3) == 0) slen = 16'($urandom_range(0, 1));
      byte_buf.push_back(BYTE_FF);
      byte_buf.push_back(mk);
      byte_buf.push_back(slen[7:0]);
      byte_buf.push_back(slen[15:8]);
      repeat (body) byte_buf.push_back(rnd_byte());
    end
    ending = $urandom_range(0, 9);
    if (ending < 7) begin
      body = $urandom_range(0, 4);
      slen = 16'(body + 2);
      if (body == 0 && $urandom_range(0, 3) == 0) slen = 16'($urandom_range(0, 1));
      byte_buf.push_back(BYTE_FF);
      byte_buf.push_back(MRK_SOS);
      byte_buf.push_back(slen[7:0]);
      byte_buf.push_back(slen[15:8]);
      repeat (body) byte_buf.push_back(rnd_byte());
      repeat ($urandom_range(0, 10)) byte_buf.push_back(scan_byte());
      // last two bytes come out as the end-of-image marker
      byte_buf.push_back(rnd_byte());
      byte_buf.push_back(rnd_byte());
    end else if (ending < 9) begin
      byte_buf.push_back(BYTE_FF);
      byte_buf.push_back(MRK_EOI);
    end else begin
      byte_buf.push_back(BYTE_FF);
      byte_buf.push_back(MRK_APP0);
      repeat ($urandom_range(0, 6)) byte_buf.push_back(rnd_byte());
    end
  endfunction

  // soi, a dropped marker, a short sof, a dqt with one body byte, sos, stuffed scan
  task automatic test_marker_block();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    // a byte with no block open is ignored
    send_byte(BYTE_FF, 1'b0, '0);
    byte_buf = {BYTE_FF, MRK_SOI, BYTE_FF, MRK_DROP, BYTE_FF, MRK_SOF, 8'h01, 8'h00,
                BYTE_FF, MRK_DQT, 8'h03, 8'h00, 8'hAA, BYTE_FF, MRK_SOS, 8'h02, 8'h00,
                BYTE_FF, 8'h33, 8'h44};
    send_block(byte_buf.size(), len_t'(byte_buf.size()));
  endtask

  task automatic test_special_cases();
    // empty block, then a byte after the block has ended
    send_byte(8'h5A, 1'b1, '0);
    send_byte(BYTE_FF, 1'b0, '0);
    // widest length, but no ff where a marker belongs
    send_byte(8'h00, 1'b1, 24'hFFFFFF);
    // ff after ff, and a held ff when the length runs out
    byte_buf = {BYTE_FF, BYTE_FF};
    send_block(2, 24'd2);
    // new block start abandons the open one, then an unknown marker
    send_byte(BYTE_FF, 1'b1, 24'd9);
    send_byte(BYTE_FF, 1'b1, 24'd2);
    send_byte(8'h12, 1'b0, '0);
    // empty dht, then app0 passes the rest through
    byte_buf = {BYTE_FF, MRK_DHT, 8'h00, 8'h00, BYTE_FF, MRK_APP0, 8'h55, 8'hA5};
    send_block(byte_buf.size(), len_t'(byte_buf.size()));
  endtask

  // receiver holds off while a scan full of ff keeps the sender busy
  task automatic test_receiver_hold();
    int k;
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    byte_buf = {BYTE_FF, MRK_SOI, BYTE_FF, MRK_SOS, 8'h02, 8'h00};
    for (k = 0; k < 24; k++) byte_buf.push_back((k % 3 == 0) ? 8'h7E : BYTE_FF);
    byte_buf.push_back(8'h00);
    byte_buf.push_back(8'h00);
    rx_long_hold = 1'b1;
    send_block(byte_buf.size(), len_t'(byte_buf.size()));
  endtask

  // mostly well-formed blocks, some damaged ones and some noise, in four idling phases
  task automatic test_random_streams();
    int   base;
    int   goal;
    int   sz;
    int   idx;
    int   nb;
    len_t decl;
    base = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_on  = (phase == 0) || (phase == 3);
      rx_stall_on = (phase == 0) || (phase == 2);
      goal = base + (TOTAL_ITEMS - base) * (phase + 1) / 4;
      while (items_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            build_jpeg_block();
            send_block(byte_buf.size(), len_t'(byte_buf.size()));
          end
          7, 8: begin
            build_jpeg_block();
            sz = byte_buf.size();
            case ($urandom_range(0, 3))
              0: begin
                // one byte overwritten, lengths and markers included
                byte_buf[$urandom_range(0, sz - 1)] = rnd_byte();
                send_block(sz, len_t'(sz));
              end
              1: begin
                // length runs out early, one byte past the end is ignored
                decl = len_t'($urandom_range(1, sz - 1));
                send_block(int'(decl) + 1, decl);
              end
              2: begin
                // length too long: unless an eoi closes it, the block stays open until the next block start
                decl = len_t'(sz + $urandom_range(1, 2000));
                send_block(sz, decl);
              end
              default: begin
                idx = $urandom_range(1, sz - 1);
                byte_buf.insert(idx, BYTE_FF);
                send_block(sz + 1, len_t'(sz + 1));
              end
            endcase
          end
          default: begin
            nb = $urandom_range(1, 6);
            byte_buf.delete();
            repeat (nb) byte_buf.push_back(rnd_byte());
            decl = ($urandom_range(0, 7) == 0) ? len_t'(0) : len_t'($urandom());
            send_block(nb, decl);
          end
        endcase
        if ($urandom_range(0, 19) == 0) send_byte(rnd_byte(), 1'b0, len_t'($urandom()));
      end
    end
  endtask

  // receiver side: random stalls, and one long hold-off on request
  initial begin : rx_side
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_long_hold = 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    rep_byte_t got;
    rep_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_byte, out_ch.byte_present, out_ch.run_last, out_ch.block_end};
      if (repaired_q.size() == 0) begin
        note_fault($sformatf("unexpected result: byte %02h present %0b last %0b end %0b",
                             got.out_byte, got.byte_present, got.run_last, got.block_end));
      end else begin
        want = repaired_q.pop_front();
        if (got !== want)
          note_fault($sformatf({"mismatch: expected byte %02h present %0b last %0b end %0b,",
                                " got byte %02h present %0b last %0b end %0b"},
                               want.out_byte, want.byte_present, want.run_last, want.block_end,
                               got.out_byte, got.byte_present, got.run_last, got.block_end));
      end
    end
  end

  // run ends if neither channel sees a transfer for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, repaired_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    clk          = 1'b0;
    rst_n        = 1'b0;
    items_sent   = 0;
    faults       = 0;
    quiet_cycles = 0;
    tx_idle_on   = 1'b1;
    rx_stall_on  = 1'b1;
    rx_long_hold = 1'b0;
    pm_mode      = MODE_IDLE;
    pm_ff_held   = 1'b0;
    pm_in_sos    = 1'b0;
    pm_len_lo    = '0;
    pm_seg_left  = '0;
    pm_pos       = '0;
    pm_total     = '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= '0;
    in_ch.block_start  <= 1'b0;
    in_ch.block_length <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_marker_block();
    wait_drained();
    test_special_cases();
    wait_drained();
    test_receiver_hold();
    wait_drained();
    test_random_streams();
    wait_drained();

    if (faults == 0 && repaired_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
